// File: sv/pseu_pkg.sv
// shared constants and tables for the phase shift extrapolation unit
// no dependencies
package pseu_pkg;

  localparam int SAMPLE_WIDTH_DEF    = 24;
  localparam int ROTATION_STAGES_DEF = 20;

  localparam int OVV_W  = 23;
  localparam int COS_W  = 17;
  localparam int DZ_W   = 20;
  localparam int KX_W   = 24;
  localparam int DEP_W  = 13;
  localparam int K2_W   = 46;
  localparam int KX2_W  = 48;
  localparam int ROOT_W = 23;
  localparam int DD_W   = DEP_W + DZ_W;
  localparam int PH_W   = 56;
  localparam int RED_W  = 31;
  localparam int ANG_W  = 32;
  localparam int MOD_STEPS = 26;

  localparam logic [RED_W-1:0] Q_TWO_PI  = 31'd1686629711;
  localparam logic [RED_W-1:0] Q_PI      = 31'd843314855;
  localparam logic [RED_W-1:0] Q_HALF_PI = 31'd421657428;
  localparam logic [24:0]      GAIN_Q24  = 25'd10187995;

  typedef enum logic [1:0] {
    REGION_PROP = 2'd0,
    REGION_EVAN = 2'd1,
    REGION_DIP  = 2'd2
  } region_t;

  typedef enum logic [1:0] {
    REG_OVV = 2'd0,
    REG_COS = 2'd1,
    REG_DZ  = 2'd2
  } reg_idx_t;

  function automatic logic signed [ANG_W-1:0] atan_q28(input int i);
    logic signed [ANG_W-1:0] r;
    case (i)
      0: r = 32'sd210828714;
      1: r = 32'sd124459457;
      2: r = 32'sd65760959;
      3: r = 32'sd33381290;
      4: r = 32'sd16755422;
      5: r = 32'sd8385879;
      6: r = 32'sd4193963;
      7: r = 32'sd2097109;
      8: r = 32'sd1048571;
      9: r = 32'sd524287;
      10: r = 32'sd262144;
      11: r = 32'sd131072;
      12: r = 32'sd65536;
      13: r = 32'sd32768;
      14: r = 32'sd16384;
      15: r = 32'sd8192;
      16: r = 32'sd4096;
      17: r = 32'sd2048;
      18: r = 32'sd1024;
      19: r = 32'sd512;
      20: r = 32'sd256;
      21: r = 32'sd128;
      22: r = 32'sd64;
      23: r = 32'sd32;
      24: r = 32'sd16;
      25: r = 32'sd8;
      26: r = 32'sd4;
      27: r = 32'sd2;
      28: r = 32'sd1;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

endpackage

// File: sv/pseu_sqrt_cell.sv
// one bit of the pipelined integer square root
// depends on pseu_pkg
module pseu_sqrt_cell #(
  parameter int BIT    = 0,
  parameter int SIDE_W = 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            v_in,
  input  logic [pseu_pkg::K2_W-1:0]       rem_in,
  input  logic [pseu_pkg::ROOT_W-1:0]     root_in,
  input  logic [SIDE_W-1:0]               side_in,
  output logic                            v_out,
  output logic [pseu_pkg::K2_W-1:0]       rem_out,
  output logic [pseu_pkg::ROOT_W-1:0]     root_out,
  output logic [SIDE_W-1:0]               side_out
);
  logic [47:0] trial;
  logic        take;

  // (root + 2^b)^2 - root^2
  assign trial = ({25'd0, root_in} << (BIT + 1)) + (48'd1 << (2 * BIT));
  assign take  = {2'b00, rem_in} >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
    if (en) begin
      rem_out  <= take ? rem_in - trial[pseu_pkg::K2_W-1:0] : rem_in;
      root_out <= take ? root_in | (23'd1 << BIT) : root_in;
      side_out <= side_in;
    end
  end
endmodule

// File: sv/pseu_mod_cell.sv
// one compare and subtract step of the phase reduction modulo 2*pi
// depends on pseu_pkg
module pseu_mod_cell #(
  parameter int SHIFT  = 0,
  parameter int SIDE_W = 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          v_in,
  input  logic [pseu_pkg::PH_W-1:0]     ph_in,
  input  logic [SIDE_W-1:0]             side_in,
  output logic                          v_out,
  output logic [pseu_pkg::PH_W-1:0]     ph_out,
  output logic [SIDE_W-1:0]             side_out
);
  logic [pseu_pkg::PH_W+1:0] step;

  assign step = {27'd0, pseu_pkg::Q_TWO_PI} << SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
    if (en) begin
      if ({2'b00, ph_in} >= step) begin
        ph_out <= ph_in - step[pseu_pkg::PH_W-1:0];
      end else begin
        ph_out <= ph_in;
      end
      side_out <= side_in;
    end
  end
endmodule

// File: sv/pseu_cordic_cell.sv
// one rotation-mode cordic micro-rotation
// depends on pseu_pkg
module pseu_cordic_cell #(
  parameter int STEP   = 0,
  parameter int XW     = 30,
  parameter int SIDE_W = 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              v_in,
  input  logic signed [XW-1:0]              x_in,
  input  logic signed [XW-1:0]              y_in,
  input  logic signed [pseu_pkg::ANG_W-1:0] a_in,
  input  logic [SIDE_W-1:0]                 side_in,
  output logic                              v_out,
  output logic signed [XW-1:0]              x_out,
  output logic signed [XW-1:0]              y_out,
  output logic signed [pseu_pkg::ANG_W-1:0] a_out,
  output logic [SIDE_W-1:0]                 side_out
);
  logic signed [XW-1:0]              dx;
  logic signed [XW-1:0]              dy;
  logic signed [pseu_pkg::ANG_W-1:0] da;

  assign dx = y_in >>> STEP;
  assign dy = x_in >>> STEP;
  assign da = pseu_pkg::atan_q28(STEP);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
    if (en) begin
      if (a_in >= 0) begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        a_out <= a_in - da;
      end else begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        a_out <= a_in + da;
      end
      side_out <= side_in;
    end
  end
endmodule

// File: sv/phase_shift_extrapolation_unit.sv
// top level of the dip-limited phase shift extrapolation unit
// depends on pseu_pkg, pseu_sqrt_cell, pseu_mod_cell, pseu_cordic_cell
//
// Applies exp(-i*depth*dz*kz) to one complex kx-omega sample per clock, or zeroes the
// sample when it is evanescent or beyond the dip limit (reported on region). A new
// transaction is taken every cycle while in_stall is low; the unit is one long pipeline
// made of three chains of cells: 23 square-root cells (one root bit each), 26 cells
// reducing the phase modulo 2*pi (one quotient bit each) and ROTATION_STAGES cordic
// cells, plus three front stages (squares, dip products, dip compare), one phase
// multiply, one angle setup stage, one gain multiply and the output register. The
// whole pipeline holds only while a finished result sits in the output register with
// out_stall high, so in_stall is exactly that condition. Configuration goes through
// the apb port (omega/v at 0x0, cos^2 of dip at 0x4, dz at 0x8) and must only change
// while no transaction is in flight.
module phase_shift_extrapolation_unit #(
  parameter int SAMPLE_WIDTH    = pseu_pkg::SAMPLE_WIDTH_DEF,
  parameter int ROTATION_STAGES = pseu_pkg::ROTATION_STAGES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // apb config port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [3:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_real,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_imag,
  input  logic signed [23:0]             wavenumber,
  input  logic [12:0]                    mirror_depth,
  // output channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] result_real,
  output logic signed [SAMPLE_WIDTH-1:0] result_imag,
  output logic [1:0]                     region
);
  localparam int SW     = SAMPLE_WIDTH;
  localparam int XW     = SW + 6;
  localparam int NSQ    = pseu_pkg::ROOT_W;
  localparam int NMOD   = pseu_pkg::MOD_STEPS;
  localparam int NROT   = ROTATION_STAGES;
  localparam int SQ_SW  = 2 * SW + 2 + pseu_pkg::DD_W;  // x, y, region, depth*dz
  localparam int MD_SW  = 2 * SW + 2;                   // x, y, region
  localparam int PW     = XW + 25;                      // gain product width

  // configuration registers
  logic [pseu_pkg::OVV_W-1:0] omega_over_velocity;
  logic [pseu_pkg::COS_W-1:0] cos_dip_squared;
  logic [pseu_pkg::DZ_W-1:0]  depth_step;
  logic                       cfg_we;
  pseu_pkg::reg_idx_t         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = pseu_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      omega_over_velocity <= '0;
      cos_dip_squared     <= 17'd65536;
      depth_step          <= 20'd256;
    end else if (cfg_we) begin
      case (cfg_idx)
        pseu_pkg::REG_OVV: omega_over_velocity <= pwdata[pseu_pkg::OVV_W-1:0];
        pseu_pkg::REG_COS: cos_dip_squared     <= pwdata[pseu_pkg::COS_W-1:0];
        pseu_pkg::REG_DZ:  depth_step          <= pwdata[pseu_pkg::DZ_W-1:0];
        default: ;  // unmapped register, write dropped
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      pseu_pkg::REG_OVV: prdata = {9'd0, omega_over_velocity};
      pseu_pkg::REG_COS: prdata = {15'd0, cos_dip_squared};
      pseu_pkg::REG_DZ:  prdata = {12'd0, depth_step};
      default:           prdata = '0;
    endcase
  end

  // global advance: everything moves unless the output transaction is held
  logic en;
  assign en       = ~(out_valid & out_stall);
  assign in_stall = ~en;

  // stage 1: squares and depth*dz
  logic                         v1;
  logic [SW-1:0]                x1, y1;
  logic [pseu_pkg::KX2_W-1:0]   kx2_1;
  logic [pseu_pkg::K2_W-1:0]    k2_1;
  logic [pseu_pkg::COS_W-1:0]   cos1;
  logic [pseu_pkg::DD_W-1:0]    dd1;
  logic [23:0]                  kxa;

  assign kxa = wavenumber[23] ? 24'(-wavenumber) : 24'(wavenumber);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      x1    <= sample_real;
      y1    <= sample_imag;
      kx2_1 <= kxa * kxa;
      k2_1  <= omega_over_velocity * omega_over_velocity;
      cos1  <= cos_dip_squared;
      dd1   <= mirror_depth * depth_step;
    end
  end

  // stage 2: kz^2, evanescent test, cos^2*k^2 in two halves
  logic                      v2, evan2;
  logic [SW-1:0]             x2, y2;
  logic [pseu_pkg::K2_W-1:0] kz2_2;
  logic [39:0]               plo2, phi2;
  logic [pseu_pkg::DD_W-1:0] dd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      x2    <= x1;
      y2    <= y1;
      evan2 <= kx2_1 > {2'b00, k2_1};
      kz2_2 <= k2_1 - kx2_1[pseu_pkg::K2_W-1:0];
      plo2  <= cos1 * k2_1[22:0];
      phi2  <= cos1 * k2_1[45:23];
      dd2   <= dd1;
    end
  end

  // stage 3: dip limit compare, region decided
  logic                      v3;
  logic [SW-1:0]             x3, y3;
  logic [1:0]                reg3;
  logic [pseu_pkg::K2_W-1:0] kz2_3;
  logic [pseu_pkg::DD_W-1:0] dd3;
  logic [63:0]               lhs2, rhs2;

  assign lhs2 = {2'b00, kz2_2, 16'd0};
  assign rhs2 = {24'd0, plo2} + {1'b0, phi2, 23'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      x3    <= x2;
      y3    <= y2;
      kz2_3 <= kz2_2;
      dd3   <= dd2;
      if (evan2) begin
        reg3 <= pseu_pkg::REGION_EVAN;
      end else if (lhs2 <= rhs2) begin
        reg3 <= pseu_pkg::REGION_DIP;
      end else begin
        reg3 <= pseu_pkg::REGION_PROP;
      end
    end
  end

  // square root chain, one root bit per cell, msb first
  logic [NSQ:0]                        sq_v;
  logic [NSQ:0][pseu_pkg::K2_W-1:0]    sq_rem;
  logic [NSQ:0][pseu_pkg::ROOT_W-1:0]  sq_root;
  logic [NSQ:0][SQ_SW-1:0]             sq_side;

  assign sq_v[0]    = v3;
  assign sq_rem[0]  = kz2_3;
  assign sq_root[0] = '0;
  assign sq_side[0] = {x3, y3, reg3, dd3};

  for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
    pseu_sqrt_cell #(.BIT(NSQ - 1 - g), .SIDE_W(SQ_SW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .v_in     (sq_v[g]),
      .rem_in   (sq_rem[g]),
      .root_in  (sq_root[g]),
      .side_in  (sq_side[g]),
      .v_out    (sq_v[g+1]),
      .rem_out  (sq_rem[g+1]),
      .root_out (sq_root[g+1]),
      .side_out (sq_side[g+1])
    );
  end

  // phase = depth * dz * kz
  logic                      vp;
  logic [MD_SW-1:0]          sidep;
  logic [pseu_pkg::PH_W-1:0] php;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
    end else if (en) begin
      vp <= sq_v[NSQ];
    end
    if (en) begin
      sidep <= sq_side[NSQ][SQ_SW-1:pseu_pkg::DD_W];
      php   <= sq_side[NSQ][pseu_pkg::DD_W-1:0] * sq_root[NSQ];
    end
  end

  // modulo 2*pi chain, one quotient bit per cell
  logic [NMOD:0]                     md_v;
  logic [NMOD:0][pseu_pkg::PH_W-1:0] md_ph;
  logic [NMOD:0][MD_SW-1:0]          md_side;

  assign md_v[0]    = vp;
  assign md_ph[0]   = php;
  assign md_side[0] = sidep;

  for (genvar g = 0; g < NMOD; g++) begin : g_mod
    pseu_mod_cell #(.SHIFT(NMOD - 1 - g), .SIDE_W(MD_SW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .v_in     (md_v[g]),
      .ph_in    (md_ph[g]),
      .side_in  (md_side[g]),
      .v_out    (md_v[g+1]),
      .ph_out   (md_ph[g+1]),
      .side_out (md_side[g+1])
    );
  end

  // angle setup: rotate by -r, fold into +-pi/2 by an exact quarter turn, scale by 16
  logic [pseu_pkg::RED_W-1:0]        red;
  logic signed [pseu_pkg::ANG_W-1:0] ang0;
  logic signed [SW-1:0]              mx, my;
  logic signed [XW-1:0]              sx, sy;
  logic signed [pseu_pkg::ANG_W-1:0] half_pi;

  assign red     = md_ph[NMOD][pseu_pkg::RED_W-1:0];
  assign mx      = md_side[NMOD][MD_SW-1 -: SW];
  assign my      = md_side[NMOD][SW+1 -: SW];
  assign sx      = XW'($signed({mx, 4'd0}));
  assign sy      = XW'($signed({my, 4'd0}));
  assign half_pi = $signed({1'b0, pseu_pkg::Q_HALF_PI});
  assign ang0    = (red > pseu_pkg::Q_PI) ? $signed({1'b0, pseu_pkg::Q_TWO_PI - red})
                                          : -$signed({1'b0, red});

  logic [NROT:0]                              ro_v;
  logic signed [NROT:0][XW-1:0]               ro_x, ro_y;
  logic signed [NROT:0][pseu_pkg::ANG_W-1:0]  ro_a;
  logic [NROT:0][1:0]                         ro_side;

  // setup stage registers feeding the head of the cordic chain
  logic                              rs_v;
  logic signed [XW-1:0]              rs_x, rs_y;
  logic signed [pseu_pkg::ANG_W-1:0] rs_a;
  logic [1:0]                        rs_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      rs_v <= 1'b0;
    end else if (en) begin
      rs_v <= md_v[NMOD];
    end
    if (en) begin
      rs_side <= md_side[NMOD][1:0];
      if (ang0 > half_pi) begin
        rs_x <= -sy;
        rs_y <= sx;
        rs_a <= ang0 - half_pi;
      end else if (ang0 < -half_pi) begin
        rs_x <= sy;
        rs_y <= -sx;
        rs_a <= ang0 + half_pi;
      end else begin
        rs_x <= sx;
        rs_y <= sy;
        rs_a <= ang0;
      end
    end
  end

  assign ro_v[0]    = rs_v;
  assign ro_x[0]    = rs_x;
  assign ro_y[0]    = rs_y;
  assign ro_a[0]    = rs_a;
  assign ro_side[0] = rs_side;

  // cordic chain
  for (genvar g = 0; g < NROT; g++) begin : g_rot
    pseu_cordic_cell #(.STEP(g), .XW(XW), .SIDE_W(2)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .v_in     (ro_v[g]),
      .x_in     (ro_x[g]),
      .y_in     (ro_y[g]),
      .a_in     (ro_a[g]),
      .side_in  (ro_side[g]),
      .v_out    (ro_v[g+1]),
      .x_out    (ro_x[g+1]),
      .y_out    (ro_y[g+1]),
      .a_out    (ro_a[g+1]),
      .side_out (ro_side[g+1])
    );
  end

  // gain multiply
  logic                 vg;
  logic signed [PW-1:0] gx, gy;
  logic [1:0]           regg;

  always_ff @(posedge clk) begin
    if (rst) begin
      vg <= 1'b0;
    end else if (en) begin
      vg <= ro_v[NROT];
    end
    if (en) begin
      gx   <= PW'($signed(ro_x[NROT])) * PW'($signed({1'b0, pseu_pkg::GAIN_Q24}));
      gy   <= PW'($signed(ro_y[NROT])) * PW'($signed({1'b0, pseu_pkg::GAIN_Q24}));
      regg <= ro_side[NROT];
    end
  end

  // round half up, scale back by 2^28, saturate
  function automatic logic signed [SW-1:0] finish(input logic signed [PW-1:0] p);
    logic signed [PW:0]    s;
    logic signed [PW-28:0] q;
    logic signed [PW-28:0] hi;
    logic signed [PW-28:0] lo;
    s  = $signed({p[PW-1], p}) + $signed((PW+1)'(1) << 27);
    q  = s[PW:28];
    hi = (PW-27)'((1 << (SW - 1)) - 1);
    lo = -hi - (PW-27)'(1);
    if (q > hi) begin
      return hi[SW-1:0];
    end else if (q < lo) begin
      return lo[SW-1:0];
    end
    return q[SW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vg;
    end
    if (en) begin
      region <= regg;
      if (regg == pseu_pkg::REGION_PROP) begin
        result_real <= finish(gx);
        result_imag <= finish(gy);
      end else begin
        result_real <= '0;
        result_imag <= '0;
      end
    end
  end
endmodule

// File: sv/pseu_checker.sv
// port-level checks for phase_shift_extrapolation_unit
// depends on pseu_pkg; bound to the top level below
module pseu_checker #(
  parameter int SAMPLE_WIDTH = pseu_pkg::SAMPLE_WIDTH_DEF
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [SAMPLE_WIDTH-1:0] result_real,
  input logic [SAMPLE_WIDTH-1:0] result_imag,
  input logic [1:0]              region
);
  // input is held back only while the output transaction is held
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without held output");

  a_region_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (region == pseu_pkg::REGION_PROP || region == pseu_pkg::REGION_EVAN ||
                   region == pseu_pkg::REGION_DIP))
    else $error("bad region code");

  // zeroed regions carry zero samples
  a_zeroed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && region != pseu_pkg::REGION_PROP) |->
      (result_real == '0 && result_imag == '0))
    else $error("nonzero result in zeroed region");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(result_real) &&
                                  $stable(result_imag) && $stable(region)))
    else $error("held output changed");
endmodule

bind phase_shift_extrapolation_unit pseu_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_pseu_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .result_real (result_real),
  .result_imag (result_imag),
  .region      (region)
);
